[rtl/sav_pkg.sv]
// Shared types and constants for the snapshot array version list.
// Field widths, request and status codes, controller state type.
// No dependencies.
`timescale 1ns / 1ps

package sav_pkg;

  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 31;
  localparam int SNAP_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_SET  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SNAP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_SET_CHK,
    S_SEARCH,
    S_DONE
  } sav_state_t;

endpackage

[rtl/sav_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module sav_ram #(
  parameter int ADDR_W = 10,
  parameter int WIDTH  = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/snapshot_array_version_list.sv]
// Snapshot array version list: controller, snapshot counter and result register.
// Depends on sav_pkg and sav_ram (count memory and version memory).
//
// Usage:
//   Input channel in_valid/in_ready carries one request per transaction:
//   in_req_type (set, snap, get), in_index, in_value, in_snap_query.
//   Output channel out_valid/out_ready returns exactly one result per
//   request: out_read_value, out_snap_number, out_status.
// Sequence (one request in flight at a time, next request accepted once the
// controller is idle; each step waits on a registered memory read):
//   snap, unknown request, index out of range: straight to the result register.
//   set: count read, then on an empty list a first-version write, else a
//   read of the newest version; get: count read, then k binary search reads,
//   k at most ceil(log2(VERSIONS_PER_INDEX + 1)).
// Reset: the snapshot counter clears at once; then a clearing pass writes
//   zero to every version count, with in_ready low.
// Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and its result is held until the register frees.
`timescale 1ns / 1ps

module snapshot_array_version_list #(
  parameter int ARRAY_LENGTH       = 1024,
  parameter int MAX_SNAPSHOTS      = 65536,
  parameter int VERSIONS_PER_INDEX = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sav_pkg::REQ_W-1:0]        in_req_type,
  input  logic [sav_pkg::INDEX_W-1:0]      in_index,
  input  logic [sav_pkg::VALUE_W-1:0]      in_value,
  input  logic [sav_pkg::SNAP_W-1:0]       in_snap_query,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sav_pkg::VALUE_W-1:0]      out_read_value,
  output logic [sav_pkg::SNAP_W-1:0]       out_snap_number,
  output logic [sav_pkg::STATUS_W-1:0]     out_status
);

  import sav_pkg::*;

  localparam int IDX_W  = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
  localparam int SLOT_W = $clog2(VERSIONS_PER_INDEX);
  localparam int VC_W   = $clog2(VERSIONS_PER_INDEX + 1);
  localparam int CNT_W  = $clog2(MAX_SNAPSHOTS + 1);
  localparam int TAG_W  = CNT_W;
  localparam int VER_W  = TAG_W + VALUE_W;
  localparam int CMP_W  = (CNT_W > SNAP_W) ? CNT_W : SNAP_W;
  localparam int VA_W   = IDX_W + SLOT_W;

  localparam logic [16:0]      ALEN    = 17'(ARRAY_LENGTH);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SNAPSHOTS);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(ARRAY_LENGTH - 1);
  localparam logic [VC_W-1:0]  VPI     = VC_W'(VERSIONS_PER_INDEX);

  sav_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]      counter_r, counter_nxt;
  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [SNAP_W-1:0]     query_r, query_nxt;
  logic [VC_W-1:0]       cnt_r, cnt_nxt;
  logic [VC_W-1:0]       lo_r, lo_nxt;
  logic [VC_W-1:0]       hi_r, hi_nxt;
  logic [SLOT_W-1:0]     mid_r, mid_nxt;
  logic [VALUE_W-1:0]    found_r, found_nxt;
  logic [VALUE_W-1:0]    res_rd_r, res_rd_nxt;
  logic [SNAP_W-1:0]     res_sn_r, res_sn_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_rd_r, out_rd_nxt;
  logic [SNAP_W-1:0]     out_sn_r, out_sn_nxt;
  logic [STATUS_W-1:0]   out_st_r, out_st_nxt;

  logic                  cnt_we, cnt_re;
  logic [IDX_W-1:0]      cnt_waddr, cnt_raddr;
  logic [VC_W-1:0]       cnt_wdata, cnt_rdata;
  logic                  ver_we, ver_re;
  logic [VA_W-1:0]       ver_waddr, ver_raddr;
  logic [VER_W-1:0]      ver_wdata, ver_rdata;

  logic                  in_range;
  logic [TAG_W-1:0]      rd_tag;
  logic [VALUE_W-1:0]    rd_val;
  logic                  hit;
  logic [VC_W-1:0]       lo_step, hi_step;
  logic [VC_W:0]         sum_step;
  logic [SLOT_W-1:0]     mid_step;

  sav_ram #(.ADDR_W(IDX_W), .WIDTH(VC_W)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  sav_ram #(.ADDR_W(VA_W), .WIDTH(VER_W)) u_version_ram (
    .clk   (clk),
    .we    (ver_we),
    .waddr (ver_waddr),
    .wdata (ver_wdata),
    .re    (ver_re),
    .raddr (ver_raddr),
    .rdata (ver_rdata)
  );

  assign in_range = (17'(in_index) < ALEN);
  assign rd_tag   = ver_rdata[VER_W-1:VALUE_W];
  assign rd_val   = ver_rdata[VALUE_W-1:0];
  assign hit      = (CMP_W'(rd_tag) <= CMP_W'(query_r));
  assign lo_step  = hit ? (VC_W'(mid_r) + VC_W'(1)) : lo_r;
  assign hi_step  = hit ? hi_r : VC_W'(mid_r);
  assign sum_step = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_step = SLOT_W'(sum_step >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    query_r  <= query_nxt;
    cnt_r    <= cnt_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    found_r  <= found_nxt;
    res_rd_r <= res_rd_nxt;
    res_sn_r <= res_sn_nxt;
    res_st_r <= res_st_nxt;
    out_rd_r <= out_rd_nxt;
    out_sn_r <= out_sn_nxt;
    out_st_r <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    counter_nxt   = counter_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    query_nxt     = query_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    res_rd_nxt    = res_rd_r;
    res_sn_nxt    = res_sn_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_sn_nxt    = out_sn_r;
    out_st_nxt    = out_st_r;
    in_ready      = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = idx_r;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = IDX_W'(in_index);
    ver_we        = 1'b0;
    ver_waddr     = {idx_r, SLOT_W'(0)};
    ver_wdata     = {counter_r, val_r};
    ver_re        = 1'b0;
    ver_raddr     = {idx_r, mid_r};

    // drop the output transaction once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_r;
        cnt_wdata = '0;
        if (clr_idx_r == LAST_IX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt    = in_req_type;
          idx_nxt    = IDX_W'(in_index);
          val_nxt    = in_value;
          query_nxt  = in_snap_query;
          res_rd_nxt = '0;
          res_sn_nxt = '0;
          res_st_nxt = STAT_OK;
          state_nxt  = S_DONE;
          unique case (in_req_type) inside
            REQ_SET, REQ_GET: begin
              if (in_range) begin
                cnt_re    = 1'b1;
                state_nxt = S_COUNT;
              end
            end
            REQ_SNAP: begin
              if (counter_r >= MAX_CNT) begin
                res_st_nxt = STAT_EXHAUSTED;
              end else begin
                res_sn_nxt  = SNAP_W'(counter_r);
                counter_nxt = counter_r + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COUNT: begin
        cnt_nxt   = cnt_rdata;
        found_nxt = '0;
        if (req_r == REQ_SET) begin
          if (cnt_rdata == '0) begin
            ver_we    = 1'b1;
            ver_waddr = {idx_r, SLOT_W'(0)};
            cnt_we    = 1'b1;
            cnt_wdata = VC_W'(1);
            state_nxt = S_DONE;
          end else begin
            ver_re    = 1'b1;
            ver_raddr = {idx_r, SLOT_W'(cnt_rdata - VC_W'(1))};
            state_nxt = S_SET_CHK;
          end
        end else begin
          lo_nxt = '0;
          hi_nxt = cnt_rdata;
          if (cnt_rdata == '0) begin
            state_nxt = S_DONE;
          end else begin
            ver_re    = 1'b1;
            ver_raddr = {idx_r, SLOT_W'(cnt_rdata >> 1)};
            mid_nxt   = SLOT_W'(cnt_rdata >> 1);
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SET_CHK: begin
        // overwrite the newest version, append, or report a full list
        if (rd_tag == counter_r) begin
          ver_we    = 1'b1;
          ver_waddr = {idx_r, SLOT_W'(cnt_r - VC_W'(1))};
        end else if (cnt_r >= VPI) begin
          res_st_nxt = STAT_FULL;
        end else begin
          ver_we    = 1'b1;
          ver_waddr = {idx_r, SLOT_W'(cnt_r)};
          cnt_we    = 1'b1;
          cnt_wdata = cnt_r + VC_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (hit) begin
          found_nxt = rd_val;
        end
        if (lo_step < hi_step) begin
          ver_re    = 1'b1;
          ver_raddr = {idx_r, mid_step};
          mid_nxt   = mid_step;
        end else begin
          res_rd_nxt = hit ? rd_val : found_r;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_sn_nxt    = res_sn_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_snap_number = out_sn_r;
  assign out_status      = out_st_r;

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counter_r <= MAX_CNT)
    else $error("snapshot counter beyond its maximum");

  a_counter_on_snap: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (counter_r != $past(counter_r))) |->
      ($past(state_r) == S_IDLE && $past(in_valid) && $past(in_req_type) == REQ_SNAP))
    else $error("snapshot counter moved without a snap transaction");

  a_version_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ver_we |-> (state_r == S_COUNT || state_r == S_SET_CHK))
    else $error("version memory written outside a set");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (lo_r <= VC_W'(mid_r) && VC_W'(mid_r) < hi_r))
    else $error("search midpoint outside its bounds");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result presented without a finished request");

endmodule

[dv/testbench.sv]
// Self-checking bench for snapshot_array_version_list: directed, random and snapshot-burst
// transactions, checked against an in-bench versioned-array predictor.
// Depends on sav_pkg and the snapshot_array_version_list RTL.
`timescale 1ns / 1ps

module testbench;
  import sav_pkg::*;

  localparam int ARRAY_LEN    = 1024;
  localparam int MAX_SNAPS    = 65536;
  localparam int DEPTH        = 16;
  localparam int LIMIT_CYCLES = 500_000;
  localparam int HOT_COUNT    = 8;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [SNAP_W-1:0]   snap_number;
    logic [STATUS_W-1:0] status;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type;
  logic [INDEX_W-1:0]  in_index;
  logic [VALUE_W-1:0]  in_value;
  logic [SNAP_W-1:0]   in_snap_query;
  logic                out_valid;
  logic                out_ready;
  logic [VALUE_W-1:0]  out_read_value;
  logic [SNAP_W-1:0]   out_snap_number;
  logic [STATUS_W-1:0] out_status;

  logic [16:0]        snap_counter;
  int unsigned        list_len [ARRAY_LEN];
  logic [16:0]        list_tag [ARRAY_LEN][DEPTH];
  logic [VALUE_W-1:0] list_val [ARRAY_LEN][DEPTH];
  logic [INDEX_W-1:0] hot_index [HOT_COUNT];

  result_t pending_results[$];
  bit      idle_on;
  int      mismatch_count;
  int      sent_count;
  int      checked_count;
  int      full_count;
  int      exhausted_count;
  int      cycle_count;

  snapshot_array_version_list #(
    .ARRAY_LENGTH       (ARRAY_LEN),
    .MAX_SNAPSHOTS      (MAX_SNAPS),
    .VERSIONS_PER_INDEX (DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_snap_query   (in_snap_query),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_snap_number (out_snap_number),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic result_t apply_request(logic [REQ_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                            logic [VALUE_W-1:0] val, logic [SNAP_W-1:0] query);
    result_t     r;
    int unsigned n;
    int unsigned k;
    r = '0;
    case (kind)
      REQ_SET: begin
        if (idx < ARRAY_LEN) begin
          n = list_len[idx];
          if (n > 0 && list_tag[idx][n-1] == snap_counter) begin
            list_val[idx][n-1] = val;
          end else if (n >= DEPTH) begin
            r.status = STAT_FULL;
            full_count++;
          end else begin
            list_tag[idx][n] = snap_counter;
            list_val[idx][n] = val;
            list_len[idx]    = n + 1;
          end
        end
      end
      REQ_SNAP: begin
        if (snap_counter >= MAX_SNAPS) begin
          r.status = STAT_EXHAUSTED;
          exhausted_count++;
        end else begin
          r.snap_number = snap_counter[SNAP_W-1:0];
          snap_counter  = snap_counter + 1'b1;
        end
      end
      REQ_GET: begin
        if (idx < ARRAY_LEN) begin
          for (k = 0; k < list_len[idx]; k++) begin
            if (list_tag[idx][k] <= {1'b0, query}) r.read_value = list_val[idx][k];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [SNAP_W-1:0] pick_query();
    int unsigned top;
    top = (snap_counter >= 17'hFFFF) ? 32'hFFFF : snap_counter + 1;
    if ($urandom_range(0, 9) < 7) return SNAP_W'($urandom_range(0, top));
    return SNAP_W'($urandom);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val, input logic [SNAP_W-1:0] query);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_index      <= idx;
    in_value      <= val;
    in_snap_query <= query;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(kind, idx, val, query));
    sent_count++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_request(REQ_GET, 10'd0, '0, 16'd0);
    send_request(REQ_SET, 10'd0, '0, 16'd0);
    send_request(REQ_SET, 10'h3FF, 31'h7FFF_FFFF, 16'hFFFF);
    send_request(REQ_GET, 10'h3FF, '0, 16'd0);
    send_request(REQ_SET, 10'd0, 31'h5555_5555, 16'd0);
    send_request(REQ_SNAP, 10'h3FF, 31'h7FFF_FFFF, 16'hFFFF);
    send_request(REQ_GET, 10'd0, '0, 16'd0);
    send_request(REQ_SET, 10'd0, 31'h2AAA_AAAA, 16'd0);
    send_request(REQ_GET, 10'd0, '0, 16'd0);
    send_request(REQ_GET, 10'd0, '0, 16'd1);
    send_request(REQ_GET, 10'd0, '0, 16'hFFFF);
    send_request(REQ_UNKNOWN, 10'h3FF, 31'h7FFF_FFFF, 16'hFFFF);
    send_request(REQ_SET, 10'h2AA, 31'h1234_5678, 16'h5555);
    send_request(REQ_SNAP, 10'd0, '0, 16'd0);
    send_request(REQ_GET, 10'h155, 31'h7FFF_FFFF, 16'hAAAA);
    send_request(REQ_GET, 10'h2AA, '0, 16'd1);
    send_request(REQ_GET, 10'h2AA, '0, 16'd0);
    send_request(REQ_GET, 10'h3FF, '0, 16'hFFFF);
    send_request(REQ_UNKNOWN, 10'd0, '0, 16'd0);
  endtask

  task automatic test_version_fill();
    logic [INDEX_W-1:0] idx;
    int k;
    idx = INDEX_W'($urandom);
    while (list_len[idx] != 0) idx = INDEX_W'($urandom);
    for (k = 0; k < DEPTH - 1; k++) begin
      send_request(REQ_SET, idx, VALUE_W'($urandom), SNAP_W'($urandom));
      send_request(REQ_SNAP, INDEX_W'($urandom), VALUE_W'($urandom), SNAP_W'($urandom));
    end
    send_request(REQ_SET, idx, VALUE_W'($urandom), SNAP_W'($urandom));
    send_request(REQ_SET, idx, VALUE_W'($urandom), SNAP_W'($urandom));
    send_request(REQ_SNAP, INDEX_W'($urandom), VALUE_W'($urandom), SNAP_W'($urandom));
    send_request(REQ_SET, idx, VALUE_W'($urandom), SNAP_W'($urandom));
    send_request(REQ_GET, idx, '0, 16'd0);
    send_request(REQ_GET, idx, '0, snap_counter[SNAP_W-1:0] - 16'd5);
    send_request(REQ_GET, idx, '0, snap_counter[SNAP_W-1:0]);
    send_request(REQ_GET, idx, '0, 16'hFFFF);
  endtask

  task automatic test_random_mix(input int n_items);
    int                 done;
    int                 pick;
    logic [REQ_W-1:0]   kind;
    logic [INDEX_W-1:0] idx;
    done = 0;
    while (done < n_items) begin
      if (done % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = REQ_SET;
      else if (pick < 60) kind = REQ_SNAP;
      else if (pick < 95) kind = REQ_GET;
      else                kind = REQ_UNKNOWN;
      if ($urandom_range(0, 9) < 8) idx = hot_index[$urandom_range(0, HOT_COUNT - 1)];
      else                          idx = INDEX_W'($urandom);
      send_request(kind, idx, VALUE_W'($urandom),
                   (kind == REQ_GET) ? pick_query() : 16'($urandom));
      if (kind != REQ_UNKNOWN) done++;
    end
  endtask

  task automatic test_snap_burst(input int n_snaps);
    int k;
    idle_on = 1'b0;
    for (k = 0; k < n_snaps; k++) begin
      send_request(REQ_SNAP, INDEX_W'($urandom), VALUE_W'($urandom), SNAP_W'($urandom));
      if (k % 16 == 15) begin
        send_request(REQ_SET, hot_index[1], VALUE_W'($urandom), SNAP_W'($urandom));
        send_request(REQ_GET, hot_index[1], '0, pick_query());
      end
    end
    send_request(REQ_GET, hot_index[1], '0, 16'hFFFF);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_SET;
    in_index      <= '0;
    in_value      <= '0;
    in_snap_query <= '0;
    snap_counter   = '0;
    idle_on        = 1'b1;
    foreach (hot_index[i]) hot_index[i] = INDEX_W'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_version_fill();
    test_random_mix(700);
    wait_for_drain();
    test_random_mix(650);
    test_snap_burst(128);
    test_random_mix(120);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d transactions, %0d results checked, %0d mismatches",
             sent_count, checked_count, mismatch_count);
    $display("full-list sets: %0d, snaps past counter limit: %0d",
             full_count, exhausted_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin : drive_out_ready
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: read_value %0h snap_number %0h status %0d",
                   out_read_value, out_snap_number, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_snap_number !== want.snap_number ||
            out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: read_value %0h/%0h snap_number %0h/%0h status %0d/%0d",
                     want.read_value, out_read_value, want.snap_number, out_snap_number,
                     want.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/sav_pkg.sv
rtl/sav_ram.sv
rtl/snapshot_array_version_list.sv
dv/testbench.sv
